@@ rtl/grb_pkg.sv @@
package grb_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_CLEARED = 2'd2,
    KIND_ANSWER  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_POP,
    ST_POPWAIT,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

@@ rtl/graph_reachability_bfs_top.sv @@
// add edge and clear give their result in the cycle after the beat is taken
// query: with both nodes in range, sweeps the seen bits clear, then per dequeued node
// pops it and scans every stored edge, stopping at the goal, then posts the answer;
// one item at a time
// the edge table and seen memory are each read once per cycle
// reset clears the edge count and control state, memories hold no reset
module graph_reachability_bfs_top #(
  parameter int MAX_EDGES  = 256,
  parameter int NODE_COUNT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] node_a_i,
  input  logic [7:0] node_b_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] result_kind_o,
  output logic       path_found_o
);
  import grb_pkg::*;

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NW = $clog2(NODE_COUNT);

  logic [15:0] edge_mem [MAX_EDGES];
  logic        seen_mem [NODE_COUNT];
  logic [7:0]  queue_mem [NODE_COUNT];

  state_e state_q, state_d;
  logic [EW:0] total_q, total_d;
  logic [EW:0] eidx_q, eidx_d;
  logic [NW:0] head_q, head_d, tail_q, tail_d;
  logic [NW:0] sweep_q, sweep_d;
  logic [7:0]  here_q, here_d, start_q, start_d, goal_q, goal_d;
  logic        ovalid_q, ovalid_d, found_q, found_d;
  logic [1:0]  kind_q, kind_d;
  logic        live1_q, live1_d, live2_q, live2_d;
  logic [15:0] e_pipe_q;

  // memory ports
  logic        e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [15:0] e_wdata, e_rdata_q;
  logic        s_we, s_wdata, s_rdata_q;
  logic [NW-1:0] s_waddr, s_raddr;
  logic        q_we;
  logic [NW-1:0] q_waddr, q_raddr;
  logic [7:0]  q_wdata, q_rdata_q;

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_waddr] <= e_wdata;
    e_rdata_q <= edge_mem[e_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (s_we) seen_mem[s_waddr] <= s_wdata;
    s_rdata_q <= seen_mem[s_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (q_we) queue_mem[q_waddr] <= q_wdata;
    q_rdata_q <= queue_mem[q_raddr];
  end

  // last written seen entry, forwarded over a read of the same node
  logic          fwd_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else begin
      fwd_v_q <= s_we && (s_waddr == s_raddr);
    end
  end

  // edge stage aligned with the seen bit read from its dst
  always_ff @(posedge clk_i) e_pipe_q <= e_rdata_q;

  logic out_free, accept, a_ok, b_ok;
  logic [7:0] src, dst;
  logic dst_seen, dst_ok;
  assign out_free = !ovalid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept = in_valid_i && !in_stall_o;
  assign a_ok = 32'(node_a_i) < NODE_COUNT;
  assign b_ok = 32'(node_b_i) < NODE_COUNT;
  assign src = e_pipe_q[15:8];
  assign dst = e_pipe_q[7:0];
  assign dst_ok = 32'(dst) < NODE_COUNT;
  assign dst_seen = s_rdata_q || fwd_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      ovalid_q <= 1'b0;
      live1_q <= 1'b0;
      live2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      ovalid_q <= ovalid_d;
      live1_q <= live1_d;
      live2_q <= live2_d;
    end
  end
  always_ff @(posedge clk_i) begin
    eidx_q <= eidx_d; head_q <= head_d; tail_q <= tail_d; sweep_q <= sweep_d;
    here_q <= here_d; start_q <= start_d; goal_q <= goal_d;
    found_q <= found_d; kind_q <= kind_d;
  end

  always_comb begin
    state_d = state_q; total_d = total_q; eidx_d = eidx_q;
    head_d = head_q; tail_d = tail_q; sweep_d = sweep_q;
    here_d = here_q; start_d = start_q; goal_d = goal_q;
    found_d = found_q; kind_d = kind_q; live1_d = 1'b0; live2_d = 1'b0;
    ovalid_d = ovalid_q && out_stall_i;
    e_we = 1'b0; e_waddr = total_q[EW-1:0]; e_wdata = {node_a_i, node_b_i};
    e_raddr = eidx_q[EW-1:0];
    s_we = 1'b0; s_waddr = sweep_q[NW-1:0]; s_wdata = 1'b0;
    s_raddr = e_rdata_q[NW-1:0];
    q_we = 1'b0; q_waddr = tail_q[NW-1:0]; q_wdata = dst;
    q_raddr = head_q[NW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_ADD: begin
              ovalid_d = 1'b1; found_d = 1'b0;
              if (32'(total_q) >= MAX_EDGES || !a_ok || !b_ok) begin
                kind_d = KIND_DROPPED;
              end else begin
                e_we = 1'b1; total_d = total_q + 1'b1; kind_d = KIND_STORED;
              end
            end
            CMD_CLEAR: begin
              ovalid_d = 1'b1; found_d = 1'b0; total_d = '0; kind_d = KIND_CLEARED;
            end
            CMD_QUERY: begin
              kind_d = KIND_ANSWER; found_d = 1'b0;
              if (a_ok && b_ok) begin
                start_d = node_a_i; goal_d = node_b_i; sweep_d = '0;
                state_d = ST_SWEEP;
              end else begin
                ovalid_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        s_we = 1'b1; s_wdata = 1'b0;
        sweep_d = sweep_q + 1'b1;
        if (32'(sweep_q) == NODE_COUNT - 1) begin
          state_d = ST_POP;
          s_wdata = 1'b0;
          q_we = 1'b1; q_waddr = '0; q_wdata = start_q;
          head_d = '0; tail_d = (NW+1)'(1);
        end
      end
      ST_POP: begin
        // mark start seen on the first pop, reads queue head
        if (head_q == '0) begin
          s_we = 1'b1; s_waddr = start_q[NW-1:0]; s_wdata = 1'b1;
        end
        if (head_q < tail_q && 32'(head_q) < NODE_COUNT) begin
          state_d = ST_POPWAIT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POPWAIT: begin
        here_d = q_rdata_q; head_d = head_q + 1'b1;
        eidx_d = '0; e_raddr = '0;
        if (total_q == '0) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_SCAN; eidx_d = (EW+1)'(1); live1_d = 1'b1;
        end
      end
      ST_SCAN: begin
        // e_rdata_q holds the fetched edge and addresses the seen read of its dst,
        // e_pipe_q holds the edge before it together with its seen bit
        if (eidx_q < total_q) begin
          eidx_d = eidx_q + 1'b1; live1_d = 1'b1;
        end
        live2_d = live1_q;
        if (live2_q && src == here_q) begin
          if (dst == goal_q) begin
            found_d = 1'b1; state_d = ST_DONE; live1_d = 1'b0; live2_d = 1'b0;
          end else if (dst_ok && !dst_seen && 32'(tail_q) < NODE_COUNT) begin
            s_we = 1'b1; s_waddr = dst[NW-1:0]; s_wdata = 1'b1;
            q_we = 1'b1; tail_d = tail_q + 1'b1;
          end
        end
        // last edge decided this cycle
        if (state_d == ST_SCAN && !live1_q) begin
          state_d = ST_POP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign result_kind_o = kind_q;
  assign path_found_o = found_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(total_q) <= MAX_EDGES)) else $error("edge count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
endmodule
